/* hdl/mts_pkg.sv */
`timescale 1ns / 1ps

package mts_pkg;

    // Request kinds
    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_PEEK = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam int unsigned COUNT_W = 11;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        logic signed [31:0] top_value;
        logic signed [31:0] min_value;
    } rsp_t;

    // One stack entry: the value and the minimum of it and everything below
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] run_min;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       load_top;
        logic       load_rsp;
        logic [1:0] status;
    } mts_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
    } mts_stat_t;

endpackage

/* hdl/mts_ctrl.sv */
`timescale 1ns / 1ps

module mts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         req_kind,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  mts_pkg::mts_stat_t stat,
    output mts_pkg::mts_cmd_t  cmd
);
    import mts_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOAD = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic accept;

    // Take a request only when idle and the response slot is free or draining
    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    // Decode the request into datapath commands
    always_comb
    begin
        cmd          = '0;
        cmd.status   = ST_OK;
        cmd.load_top = (state_reg == S_LOAD);
        if (accept)
        begin
            unique case (req_kind)
                KIND_PUSH:
                begin
                    if (stat.full)
                        cmd.status = ST_OVERFLOW;
                    else
                        cmd.push = 1'b1;
                end
                KIND_POP:
                begin
                    if (stat.empty)
                        cmd.status = ST_UNDERFLOW;
                    else
                        cmd.pop = 1'b1;
                end
                default:
                begin
                    cmd.status = ST_OK;
                end
            endcase
        end
        // A successful pop answers after the new top comes back from memory
        cmd.load_rsp = (accept && !cmd.pop) || (state_reg == S_LOAD);
    end

    // Advance the state and the response valid flag
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.pop)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_rsp)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

/* hdl/mts_datapath.sv */
`timescale 1ns / 1ps

module mts_datapath #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] push_value,
    input  mts_pkg::mts_cmd_t  cmd,
    output mts_pkg::mts_stat_t stat,
    output mts_pkg::rsp_t      rsp
);
    import mts_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    entry_t             rd_data_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic signed [31:0] top_reg;
    logic signed [31:0] top_next;
    logic signed [31:0] min_reg;
    logic signed [31:0] min_next;
    logic signed [31:0] push_min;
    logic               count_zero_next;
    rsp_t               rsp_reg;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

    // Push lands at the current count; a pop fetches the entry below the top
    assign wr_addr = AW'(count_reg);
    assign rd_addr = AW'(count_reg - CW'(2));

    // Running minimum of the pushed value and the cached minimum below it
    assign push_min = (!stat.empty && (min_reg < push_value)) ? min_reg : push_value;

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        min_next   = min_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
            top_next   = push_value;
            min_next   = push_min;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (cmd.load_top)
        begin
            top_next = rd_data_reg.value;
            min_next = rd_data_reg.run_min;
        end
    end

    assign count_zero_next = (count_next == '0);

    // Hold the entry count and the cached top entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        min_reg <= min_next;
    end

    // Stack memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[wr_addr] <= '{value: push_value, run_min: push_min};
        if (cmd.pop)
            rd_data_reg <= mem[rd_addr];
    end

    // Capture the response; an empty stack reads zero for top and minimum
    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            rsp_reg.status      <= cmd.status;
            rsp_reg.entry_count <= COUNT_W'(count_next);
            rsp_reg.is_empty    <= count_zero_next;
            rsp_reg.top_value   <= count_zero_next ? 32'sd0 : top_next;
            rsp_reg.min_value   <= count_zero_next ? 32'sd0 : min_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

/* hdl/min_tracking_stack.sv */
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// request   req_valid / req_ready   req  (kind, push_value)
// response  rsp_valid / rsp_ready   rsp  (status, entry_count, is_empty, top_value, min_value)
//
// Push, peek and rejected operations answer in the cycle after acceptance.
// A pop that removes an entry first reads the new top from the stack memory
// through its registered read port, then the response loads.
// Reset clears the entry count; memory contents are left as they are.
// A stalled response holds; a new request is taken as the response drains.

module min_tracking_stack #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mts_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mts_pkg::rsp_t  rsp
);
    import mts_pkg::*;

    mts_cmd_t  cmd;
    mts_stat_t stat;

    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_kind  (req.kind),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mts_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_value (req.push_value),
        .cmd        (cmd),
        .stat       (stat),
        .rsp        (rsp)
    );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import mts_pkg::*;

    localparam int unsigned STACK_DEPTH = 1024;
    // Kind code 3 has no name in the package; the block treats it as a peek
    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned DRAIN_OPS   = 450;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // Shadow copy of the stack contents and fill level
    logic signed [31:0] shadow_value [STACK_DEPTH];
    logic signed [31:0] shadow_min [STACK_DEPTH];
    int unsigned        shadow_count = 0;

    rsp_t        pending_rsp_q[$];
    int unsigned errors = 0;
    int unsigned burst_left = 0;
    bit          steady_send = 1'b0;
    bit          long_hold_req = 1'b0;

    min_tracking_stack #(
        .DEPTH(STACK_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply one request to the shadow stack and return the response it should give
    function automatic rsp_t next_stack_rsp(input req_t r);
        rsp_t               o;
        logic signed [31:0] run_min;
        o = '0;
        o.status = ST_OK;
        if (r.kind == KIND_PUSH)
        begin
            if (shadow_count >= STACK_DEPTH)
                o.status = ST_OVERFLOW;
            else
            begin
                run_min = r.push_value;
                if (shadow_count > 0 && shadow_min[shadow_count - 1] < run_min)
                    run_min = shadow_min[shadow_count - 1];
                shadow_value[shadow_count] = r.push_value;
                shadow_min[shadow_count] = run_min;
                shadow_count++;
            end
        end
        else if (r.kind == KIND_POP)
        begin
            if (shadow_count == 0)
                o.status = ST_UNDERFLOW;
            else
                shadow_count--;
        end
        o.entry_count = shadow_count[COUNT_W-1:0];
        o.is_empty = (shadow_count == 0);
        if (shadow_count > 0)
        begin
            o.top_value = shadow_value[shadow_count - 1];
            o.min_value = shadow_min[shadow_count - 1];
        end
        return o;
    endfunction

    // Mix full-range, clustered, extreme and near-minimum values
    function automatic logic signed [31:0] pick_push_value();
        logic signed [31:0] v;
        logic signed [31:0] cur;
        int                 off;
        cur = (shadow_count > 0) ? shadow_min[shadow_count - 1] : 32'sd0;
        case ($urandom_range(0, 6)) inside
            [0:1]: v = $urandom;
            2:
            begin
                off = int'($urandom_range(0, 16)) - 8;
                v = off;
            end
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = 32'sd0;
                    3:       v = -32'sd1;
                    default: v = 32'sd1;
                endcase
            end
            4:       v = cur - int'($urandom_range(1, 1000));
            default:
            begin
                off = int'($urandom_range(0, 6)) - 3;
                v = cur + off;
            end
        endcase
        return v;
    endfunction

    // Offer one request, honoring the burst/gap pattern, and record its expected response
    task automatic send_request(input logic [1:0] kind, input logic signed [31:0] value);
        req_t        r;
        int unsigned gap;
        r.kind = kind;
        r.push_value = value;
        if (burst_left == 0 && !steady_send)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        pending_rsp_q.push_back(next_stack_rsp(r));
        if (burst_left != 0)
            burst_left--;
    endtask

    // Pick an operation by weight; what is left over is a peek or the unused code
    task automatic random_op(input int unsigned push_w, input int unsigned pop_w);
        int unsigned pick;
        logic [1:0]  kind;
        pick = $urandom_range(0, 99);
        if (pick < push_w)
            kind = KIND_PUSH;
        else if (pick < push_w + pop_w)
            kind = KIND_POP;
        else
            kind = ($urandom_range(0, 3) == 0) ? KIND_UNUSED : KIND_PEEK;
        send_request(kind, (kind == KIND_PUSH) ? pick_push_value() : $urandom);
    endtask

    // Drop valid and hold until every response is back
    task automatic pause_until_answered();
        req_valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic test_empty_stack();
        send_request(KIND_PEEK, $urandom);
        send_request(KIND_UNUSED, $urandom);
        send_request(KIND_POP, $urandom);
        pause_until_answered();
    endtask

    // Extremes, equal minima and unwinding of the running minimum
    task automatic test_push_pop_edges();
        send_request(KIND_PUSH, 32'sd0);
        send_request(KIND_PUSH, 32'sh7FFF_FFFF);
        send_request(KIND_PUSH, 32'sh8000_0000);
        send_request(KIND_PUSH, 32'sh8000_0000);
        send_request(KIND_PEEK, $urandom);
        send_request(KIND_PUSH, 32'sd5);
        send_request(KIND_UNUSED, $urandom);
        send_request(KIND_POP, $urandom);
        send_request(KIND_POP, $urandom);
        send_request(KIND_POP, $urandom);
        send_request(KIND_POP, $urandom);
        send_request(KIND_PUSH, -32'sd1);
        send_request(KIND_PUSH, -32'sd1);
        send_request(KIND_POP, $urandom);
        send_request(KIND_PEEK, $urandom);
        send_request(KIND_POP, $urandom);
        send_request(KIND_POP, $urandom);
        send_request(KIND_POP, $urandom);
        pause_until_answered();
    endtask

    // Keep offering while the response side holds off, so the input stalls
    task automatic test_full_back_pressure();
        int unsigned i;
        steady_send = 1'b1;
        long_hold_req = 1'b1;
        for (i = 0; i < 40; i++)
            random_op(50, 30);
        steady_send = 1'b0;
        pause_until_answered();
    endtask

    task automatic test_fill_to_overflow();
        while (shadow_count < STACK_DEPTH)
            random_op(97, 2);
        send_request(KIND_PUSH, 32'sh7FFF_FFFF);
        send_request(KIND_PUSH, 32'sh8000_0000);
        send_request(KIND_PEEK, $urandom);
        send_request(KIND_UNUSED, $urandom);
        send_request(KIND_POP, $urandom);
        send_request(KIND_PUSH, pick_push_value());
        send_request(KIND_PUSH, $urandom);
        pause_until_answered();
    endtask

    // Pop-heavy walk down from a full stack
    task automatic test_partial_drain();
        repeat (DRAIN_OPS) random_op(2, 97);
        send_request(KIND_POP, $urandom);
        send_request(KIND_POP, $urandom);
        send_request(KIND_PEEK, $urandom);
        pause_until_answered();
    endtask

    task automatic test_random_walk();
        repeat (150) random_op(40, 40);
        pause_until_answered();
    endtask

    // Response side: stall patterns of random span, plus the long hold on request
    initial
    begin : rsp_side
        int unsigned mode;
        int unsigned span;
        int unsigned period;
        int unsigned phase;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 4);
            span = $urandom_range(4, 120);
            period = $urandom_range(2, 5);
            for (phase = 0; phase < span; phase++)
            begin
                @(posedge clk);
                if (long_hold_req)
                begin
                    rsp_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                    long_hold_req = 1'b0;
                end
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= $urandom_range(0, 1);
                    2:       rsp_ready <= ($urandom_range(0, 4) != 0);
                    3:       rsp_ready <= ((phase % period) != 0);
                    default: rsp_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each delivered response with the oldest expectation
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, got %p", $time, rsp);
                errors++;
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                check_field("status", 32'(want.status), 32'(rsp.status));
                check_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
                check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
                check_field("top_value", 32'(want.top_value), 32'(rsp.top_value));
                check_field("min_value", 32'(want.min_value), 32'(rsp.min_value));
            end
        end
    end

    // End the run if neither channel moves for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("min_tracking_stack: mismatch");
        $finish;
    end

    initial
    begin : run
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_stack();
        test_push_pop_edges();
        test_full_back_pressure();
        test_fill_to_overflow();
        test_partial_drain();
        test_random_walk();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("min_tracking_stack: match");
        else
            $display("min_tracking_stack: mismatch");
        $finish;
    end

endmodule

/* min_tracking_stack.f */
hdl/mts_pkg.sv
hdl/mts_ctrl.sv
hdl/mts_datapath.sv
hdl/min_tracking_stack.sv
tb/sv/tb.sv
